[sv/lz_window_decompressor_unit_defines.svh]
// Assertion helpers shared by the decompressor modules.
`ifndef LZ_WINDOW_DECOMPRESSOR_UNIT_DEFINES_SVH
`define LZ_WINDOW_DECOMPRESSOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LZWD_ASSERT_IMP(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("lzwd assertion failed");

// Next-cycle implication, checked outside reset.
`define LZWD_ASSERT_NXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("lzwd assertion failed");

`endif

[sv/lzwd_pkg.sv]
package lzwd_pkg;

    // history window
    localparam int HistDepth = 4096;
    localparam int HistAw    = 12;

    // most lanes that a 64-bit result can hold
    localparam int OutMaxLanes = 8;

    // stream format constants
    localparam logic [7:0] FlagMsb       = 8'h80;
    localparam logic [3:0] FlagsPerGroup = 4'd8;
    localparam logic [8:0] PairLenBias   = 9'd2;
    localparam logic [8:0] ExtraLenBias  = 9'd18;

    // commands from controller to datapath
    typedef struct packed {
        logic pair_hi;     // latch first pair byte
        logic pair_lo;     // latch second pair byte, short length
        logic extra;       // latch long length byte
        logic literal;     // store literal byte and stage it
        logic copy_start;  // set source pointer and byte count
        logic mem_rd;      // read history at source pointer
        logic mem_wr;      // write read byte, stage it in a lane
        logic out_load;    // move staged bytes to output register
        logic out_last;
        logic out_fault;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic done;        // produced count reached output length
        logic nib_zero;    // pair length nibble is zero
        logic bound_fault; // copy precedes start or overruns length
        logic lane_full;   // next write fills the result
        logic last_byte;   // next write is the copy's last byte
        logic out_free;    // output register can take a result
    } t_sts;

endpackage

[sv/lzwd_dpath.sv]
`include "lz_window_decompressor_unit_defines.svh"

module lzwd_dpath import lzwd_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic [7:0]  i_byte,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic        i_out_stall,
    output logic        o_out_valid,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_run_end,
    output logic        o_copy_fault,
    output logic        o_stream_done
);

    localparam int LaneW = $clog2(LANES + 1);

    logic [31:0]       r_olen;
    logic [31:0]       r_prod;
    logic [15:0]       r_pair;
    logic [8:0]        r_len;
    logic [8:0]        r_remain;
    logic [HistAw-1:0] r_src;
    logic [7:0]        r_hist [HistDepth];
    logic [7:0]        r_rdata;
    logic [63:0]       r_acc, n_acc;
    logic [LaneW-1:0]  r_lane, n_lane;
    logic              r_ovalid;
    logic [63:0]       r_obytes;
    logic [3:0]        r_ocount;
    logic              r_olast;
    logic              r_ofault;
    logic              r_odone;

    logic [12:0]       w_dist;
    logic [31:0]       w_room;
    logic              w_we;
    logic [7:0]        w_wdata;
    logic              w_done;

    // copy geometry and bounds
    assign w_dist = {1'b0, r_pair[11:0]} + 13'd1;
    assign w_room = r_olen - r_prod;
    assign w_done = (r_prod >= r_olen);

    assign o_sts.done        = w_done;
    assign o_sts.nib_zero    = (r_pair[15:12] == 4'd0);
    assign o_sts.bound_fault = ({19'd0, w_dist} > r_prod) || ({23'd0, r_len} > w_room);
    assign o_sts.lane_full   = ((32'(r_lane) + 32'd1) == 32'(LANES));
    assign o_sts.last_byte   = (r_remain == 9'd1);
    assign o_sts.out_free    = !r_ovalid || !i_out_stall;

    // history write port: literals and copied bytes
    assign w_we    = i_cmd.literal || i_cmd.mem_wr;
    assign w_wdata = i_cmd.literal ? i_byte : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_hist[r_prod[HistAw-1:0]] <= w_wdata;
        end
        if (i_cmd.mem_rd) begin
            r_rdata <= r_hist[r_src];
        end
    end

    // lane staging
    always_comb begin
        n_acc  = r_acc;
        n_lane = r_lane;
        if (i_cmd.out_load) begin
            n_acc  = '0;
            n_lane = '0;
        end else if (i_cmd.literal) begin
            n_acc  = {56'd0, i_byte};
            n_lane = LaneW'(1);
        end else if (i_cmd.mem_wr) begin
            for (int k = 0; k < OutMaxLanes; k++) begin
                if (32'(r_lane) == k) begin
                    n_acc[8*k +: 8] = r_rdata;
                end
            end
            n_lane = r_lane + LaneW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_olen   <= '0;
            r_prod   <= '0;
            r_pair   <= '0;
            r_acc    <= '0;
            r_lane   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_olen <= i_cfg_wdata;
            end
            if (i_cmd.pair_hi) begin
                r_pair <= {i_byte, 8'h00};
            end else if (i_cmd.pair_lo) begin
                r_pair[7:0] <= i_byte;
            end
            if (i_cmd.literal || i_cmd.mem_wr) begin
                r_prod <= r_prod + 32'd1;
            end
            r_acc    <= n_acc;
            r_lane   <= n_lane;
            r_ovalid <= i_cmd.out_load || (r_ovalid && i_out_stall);
        end
    end

    // copy counters and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.pair_lo) begin
            r_len <= {5'd0, r_pair[15:12]} + PairLenBias;
        end else if (i_cmd.extra) begin
            r_len <= {1'b0, i_byte} + ExtraLenBias;
        end
        if (i_cmd.copy_start) begin
            r_src    <= r_prod[HistAw-1:0] - w_dist[HistAw-1:0];
            r_remain <= r_len;
        end else if (i_cmd.mem_wr) begin
            r_src    <= r_src + HistAw'(1);
            r_remain <= r_remain - 9'd1;
        end
        if (i_cmd.out_load) begin
            r_obytes <= r_acc;
            r_ocount <= 4'(r_lane);
            r_olast  <= i_cmd.out_last;
            r_ofault <= i_cmd.out_fault;
            r_odone  <= w_done;
        end
    end

    assign o_out_valid   = r_ovalid;
    assign o_out_bytes   = r_obytes;
    assign o_byte_count  = r_ocount;
    assign o_run_end     = r_olast;
    assign o_copy_fault  = r_ofault;
    assign o_stream_done = r_odone;

    `LZWD_ASSERT_NXT(a_out_held, i_clk, i_rst_n, r_ovalid && i_out_stall, r_ovalid)
    `LZWD_ASSERT_IMP(a_load_free, i_clk, i_rst_n, i_cmd.out_load, !r_ovalid || !i_out_stall)
    `LZWD_ASSERT_IMP(a_fault_empty, i_clk, i_rst_n, r_ovalid && r_ofault,
                     (r_ocount == 4'd0) && (r_obytes == 64'd0))

endmodule

[sv/lzwd_ctrl.sv]
`include "lz_window_decompressor_unit_defines.svh"

module lzwd_ctrl import lzwd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_byte,
    output logic       o_in_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        PH_FLAG,
        PH_CHUNK,
        PH_PAIR_LO,
        PH_EXTRA
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_RD,
        S_WR,
        S_EMIT
    } t_state;

    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [7:0] r_flags, n_flags;
    logic [3:0] r_left, n_left;
    logic       r_fault, n_fault;
    logic       r_last, n_last;
    logic       r_efault, n_efault;

    logic       w_accept;
    logic [7:0] w_fin_flags;
    logic [3:0] w_fin_left;
    t_phase     w_fin_phase;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // end of one flagged chunk
    assign w_fin_flags = {r_flags[6:0], 1'b0};
    assign w_fin_left  = (r_left != 4'd0) ? r_left - 4'd1 : 4'd0;
    assign w_fin_phase = (w_fin_left != 4'd0) ? PH_CHUNK : PH_FLAG;

    // next state and command decode
    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_flags  = r_flags;
        n_left   = r_left;
        n_fault  = r_fault;
        n_last   = r_last;
        n_efault = r_efault;
        o_cmd    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_fault) begin
                        n_efault = 1'b1;
                        n_last   = 1'b1;
                        n_state  = S_EMIT;
                    end else if (!i_sts.done) begin
                        unique case (r_phase)
                            PH_FLAG: begin
                                n_flags = i_byte;
                                n_left  = FlagsPerGroup;
                                n_phase = PH_CHUNK;
                            end
                            PH_CHUNK: begin
                                if ((r_flags & FlagMsb) != 8'd0) begin
                                    o_cmd.literal = 1'b1;
                                    n_flags  = w_fin_flags;
                                    n_left   = w_fin_left;
                                    n_phase  = w_fin_phase;
                                    n_efault = 1'b0;
                                    n_last   = 1'b1;
                                    n_state  = S_EMIT;
                                end else begin
                                    o_cmd.pair_hi = 1'b1;
                                    n_phase = PH_PAIR_LO;
                                end
                            end
                            PH_PAIR_LO: begin
                                o_cmd.pair_lo = 1'b1;
                                if (i_sts.nib_zero) begin
                                    n_phase = PH_EXTRA;
                                end else begin
                                    n_state = S_CHECK;
                                end
                            end
                            PH_EXTRA: begin
                                o_cmd.extra = 1'b1;
                                n_state = S_CHECK;
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.bound_fault) begin
                    n_fault  = 1'b1;
                    n_efault = 1'b1;
                    n_last   = 1'b1;
                    n_state  = S_EMIT;
                end else begin
                    o_cmd.copy_start = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state = S_WR;
            end
            S_WR: begin
                o_cmd.mem_wr = 1'b1;
                if (i_sts.last_byte) begin
                    n_flags  = w_fin_flags;
                    n_left   = w_fin_left;
                    n_phase  = w_fin_phase;
                end
                if (i_sts.lane_full || i_sts.last_byte) begin
                    n_last   = i_sts.last_byte;
                    n_efault = 1'b0;
                    n_state  = S_EMIT;
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load  = 1'b1;
                    o_cmd.out_last  = r_last;
                    o_cmd.out_fault = r_efault;
                    n_state = r_last ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and parser registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_FLAG;
            r_flags  <= '0;
            r_left   <= '0;
            r_fault  <= 1'b0;
            r_last   <= 1'b0;
            r_efault <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_flags  <= n_flags;
            r_left   <= n_left;
            r_fault  <= n_fault;
            r_last   <= n_last;
            r_efault <= n_efault;
        end
    end

    `LZWD_ASSERT_IMP(a_fault_last, i_clk, i_rst_n, (r_state == S_EMIT) && r_efault, r_last)
    `LZWD_ASSERT_NXT(a_fault_sticky, i_clk, i_rst_n, r_fault, r_fault)
    `LZWD_ASSERT_IMP(a_wr_after_rd, i_clk, i_rst_n, r_state == S_WR, $past(r_state) == S_RD)

endmodule

[sv/lz_window_decompressor_unit.sv]
// LZ77 window decompressor, Yaz0 payload format.
// Input channel: one compressed payload byte per transaction (header already
// stripped). Output channel: results of up to LANES bytes, first byte in bits
// 7..0, with byte count, end-of-input-byte mark, fault flag and stream-done.
// Write i_cfg_wdata with the expected output length while the block is idle.
// Timing: group bytes and pair bytes that start nothing are only accepted. A
// literal is accepted, then loaded into the output register. A copy runs a
// bounds check, then handles each byte as a read and then a write of the
// single history memory, and loads each result into the output register;
// no new input byte is accepted until the copy's last result is loaded.
// While the output register holds a stalled result, the next staged result
// waits and the input stays stalled until it is loaded; no result is dropped.
// Reset clears the parser, the produced count, the output length and the
// fault flag. The history needs no clearing; copies never reach unwritten
// entries. After a fault every byte returns one fault result until reset.
module lz_window_decompressor_unit import lzwd_pkg::*; #(
    parameter int LANES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_compressed_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_bytes,
    output logic [3:0]  o_byte_count,
    output logic        o_run_end,
    output logic        o_copy_fault,
    output logic        o_stream_done
);

    t_cmd w_cmd;
    t_sts w_sts;

    lzwd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_byte     (i_compressed_byte),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    lzwd_dpath #(
        .LANES (LANES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_byte        (i_compressed_byte),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_bytes   (o_out_bytes),
        .o_byte_count  (o_byte_count),
        .o_run_end     (o_run_end),
        .o_copy_fault  (o_copy_fault),
        .o_stream_done (o_stream_done)
    );

endmodule
